// ===== hw/rtl/svpp_pkg.sv =====
// ----------------------------------------------------------------------------
// svpp_pkg: shared types and constants of the sliced VBI packet parser
// Holds the payload structs of both channels, the descriptor that passes from
// the front end to the back end, and the fixed packet format constants.
// ----------------------------------------------------------------------------
`default_nettype none

package svpp_pkg;

    // Packet format.
    localparam int unsigned LINE_BITS  = 36;
    localparam int unsigned RECORD_LEN = 43;
    localparam int unsigned DATA_LEN   = 42;
    localparam int unsigned BODY_POS   = 12;
    localparam int unsigned COOKIE_LEN = 4;

    // Record buffer slots and their addressing.
    localparam int unsigned SLOT_COUNT = 2;
    localparam int unsigned SLOT_BITS  = 1;
    localparam int unsigned POS_BITS   = 6;
    localparam int unsigned ADDR_BITS  = SLOT_BITS + POS_BITS;
    localparam int unsigned MEM_DEPTH  = 1 << ADDR_BITS;

    // Cookie characters, lower-case and upper-case forms.
    localparam logic [7:0] CK_LO_0 = 8'h69; // 'i'
    localparam logic [7:0] CK_LO_1 = 8'h74; // 't'
    localparam logic [7:0] CK_LO_2 = 8'h76; // 'v'
    localparam logic [7:0] CK_UP_0 = 8'h49; // 'I'
    localparam logic [7:0] CK_UP_1 = 8'h54; // 'T'
    localparam logic [7:0] CK_UP_2 = 8'h56; // 'V'
    localparam logic [7:0] CK_ZERO = 8'h30; // '0', shared last character

    // Cookie kind bits.
    localparam logic [1:0] CK_NONE  = 2'd0;
    localparam logic [1:0] CK_MASK  = 2'd1;
    localparam logic [1:0] CK_ALL   = 2'd2;

    // Record type codes.
    localparam logic [7:0] TYPE_TELETEXT = 8'h01;
    localparam logic [7:0] TYPE_CAPTION  = 8'h04;
    localparam logic [7:0] TYPE_WSS      = 8'h05;
    localparam logic [7:0] TYPE_VPS      = 8'h07;

    // Service codes.
    localparam logic [2:0] SVC_TELETEXT = 3'd0;
    localparam logic [2:0] SVC_CAPTION  = 3'd1;
    localparam logic [2:0] SVC_WSS      = 3'd2;
    localparam logic [2:0] SVC_VPS      = 3'd3;
    localparam logic [2:0] SVC_UNKNOWN  = 3'd4;

    // Line mapping.
    localparam logic [5:0] LINE_SPLIT    = 6'd18;
    localparam logic [8:0] LINE_OFS_LOW  = 9'd6;
    localparam logic [8:0] LINE_OFS_CC   = 9'd251;
    localparam logic [8:0] LINE_OFS_HIGH = 9'd301;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [8:0] line_number;
        logic [2:0] service;
        logic [5:0] byte_index;
        logic [7:0] data_value;
        logic       last_of_record;
    } t_out;

    // One completed record waiting to be drained.
    typedef struct packed {
        logic [8:0] line_number;
        logic [2:0] service;
    } t_desc;

    // Write port of the record buffer.
    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
        logic [7:0]           data;
    } t_buf_wr;

    // Queue status seen by both ends.
    typedef struct packed {
        logic                 full;
        logic                 empty;
        logic [SLOT_BITS-1:0] wr_slot;
        logic [SLOT_BITS-1:0] rd_slot;
    } t_q_status;

endpackage

`default_nettype wire

// ===== hw/rtl/svpp_queue.sv =====
// ----------------------------------------------------------------------------
// svpp_queue: record descriptor queue
// Two-entry queue of completed record descriptors. Its pointers also name the
// record buffer slot that the front end fills and the back end drains.
// ----------------------------------------------------------------------------
`default_nettype none

module svpp_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire svpp_pkg::t_desc     i_push_desc,
    input  wire logic                i_pop,
    output svpp_pkg::t_desc          o_head_desc,
    output svpp_pkg::t_q_status      o_status
);

    svpp_pkg::t_desc r_entry [svpp_pkg::SLOT_COUNT];
    logic [svpp_pkg::SLOT_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [svpp_pkg::SLOT_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [svpp_pkg::SLOT_BITS:0]   r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr + (i_push ? 1'b1 : 1'b0);
        n_rd_ptr = r_rd_ptr + (i_pop ? 1'b1 : 1'b0);
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_desc;
        end
    end

    assign o_head_desc      = r_entry[r_rd_ptr];
    assign o_status.full    = (r_count == (svpp_pkg::SLOT_BITS+1)'(svpp_pkg::SLOT_COUNT));
    assign o_status.empty   = (r_count == '0);
    assign o_status.wr_slot = r_wr_ptr;
    assign o_status.rd_slot = r_rd_ptr;

endmodule

`default_nettype wire

// ===== hw/rtl/svpp_front.sv =====
// ----------------------------------------------------------------------------
// svpp_front: packet header and record parser
// Checks the cookie, collects the line mask, writes record data bytes into
// the record buffer and pushes a descriptor for each record to be emitted.
// ----------------------------------------------------------------------------
`default_nettype none

module svpp_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire svpp_pkg::t_in       i_data,
    input  wire logic                i_cfg_we,
    input  wire logic [15:0]         i_cfg_wdata,
    input  wire svpp_pkg::t_q_status i_q_status,
    output logic                     o_push,
    output svpp_pkg::t_desc          o_push_desc,
    output svpp_pkg::t_buf_wr        o_buf_wr
);

    localparam int unsigned LB = svpp_pkg::LINE_BITS;

    logic [3:0]    r_hdr_pos, n_hdr_pos;
    logic [1:0]    r_cookie, n_cookie;
    logic [LB-1:0] r_lines, n_lines;
    logic [5:0]    r_rec_pos, n_rec_pos;
    logic [7:0]    r_rec_type, n_rec_type;
    logic          r_rejected, n_rejected;
    logic          r_muted, n_muted;
    logic [15:0]   r_skip_left, n_skip_left;

    logic          accept;
    logic [1:0]    match;
    logic [1:0]    cookie_now;
    logic [LB-1:0] low_bit;
    logic [5:0]    low_idx;
    logic [8:0]    line_num;
    logic [2:0]    svc;
    logic          rec_done;

    // Which cookie forms the byte at this header position still fits.
    function automatic logic [1:0] cookie_match(input logic [1:0] pos, input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] up;
        case (pos)
            2'd0:    begin lo = svpp_pkg::CK_LO_0; up = svpp_pkg::CK_UP_0; end
            2'd1:    begin lo = svpp_pkg::CK_LO_1; up = svpp_pkg::CK_UP_1; end
            2'd2:    begin lo = svpp_pkg::CK_LO_2; up = svpp_pkg::CK_UP_2; end
            default: begin lo = svpp_pkg::CK_ZERO; up = svpp_pkg::CK_ZERO; end
        endcase
        return {b == up, b == lo};
    endfunction

    assign accept  = i_valid && !o_stall;
    assign o_stall = i_q_status.full;

    assign match      = cookie_match(r_hdr_pos[1:0], i_data.data_byte);
    assign cookie_now = (r_hdr_pos == 4'd0) ? match : (r_cookie & match);

    // Lowest line still pending; low_bit is one-hot or zero.
    always_comb begin
        low_bit = r_lines & (~r_lines + LB'(1));
        low_idx = '0;
        for (int i = 0; i < LB; i++) begin
            low_idx = low_idx | (low_bit[i] ? 6'(i) : 6'd0);
        end
    end

    always_comb begin
        if (low_idx < svpp_pkg::LINE_SPLIT) begin
            line_num = 9'(low_idx) + svpp_pkg::LINE_OFS_LOW;
        end else if (r_rec_type == svpp_pkg::TYPE_CAPTION) begin
            line_num = 9'(low_idx) + svpp_pkg::LINE_OFS_CC;
        end else begin
            line_num = 9'(low_idx) + svpp_pkg::LINE_OFS_HIGH;
        end
    end

    always_comb begin
        unique case (r_rec_type)
            svpp_pkg::TYPE_TELETEXT: svc = svpp_pkg::SVC_TELETEXT;
            svpp_pkg::TYPE_CAPTION:  svc = svpp_pkg::SVC_CAPTION;
            svpp_pkg::TYPE_WSS:      svc = svpp_pkg::SVC_WSS;
            svpp_pkg::TYPE_VPS:      svc = svpp_pkg::SVC_VPS;
            default:                 svc = svpp_pkg::SVC_UNKNOWN;
        endcase
    end

    assign rec_done = accept && !r_rejected && (r_hdr_pos >= 4'(svpp_pkg::BODY_POS))
                   && (r_rec_pos == 6'(svpp_pkg::DATA_LEN));

    assign o_push                  = rec_done && (r_lines != '0) && !r_muted;
    assign o_push_desc.line_number = line_num;
    assign o_push_desc.service     = svc;

    assign o_buf_wr.en   = accept && !r_rejected && (r_hdr_pos >= 4'(svpp_pkg::BODY_POS))
                        && (r_rec_pos != 6'd0);
    assign o_buf_wr.addr = {i_q_status.wr_slot, r_rec_pos - 6'd1};
    assign o_buf_wr.data = i_data.data_byte;

    always_comb begin
        n_hdr_pos   = r_hdr_pos;
        n_cookie    = r_cookie;
        n_lines     = r_lines;
        n_rec_pos   = r_rec_pos;
        n_rec_type  = r_rec_type;
        n_rejected  = r_rejected;
        n_muted     = r_muted;
        n_skip_left = r_skip_left;

        if (i_cfg_we) begin
            n_skip_left = i_cfg_wdata;
        end

        if (accept) begin
            if (!r_rejected) begin
                if (r_hdr_pos < 4'(svpp_pkg::COOKIE_LEN)) begin
                    n_cookie  = cookie_now;
                    n_hdr_pos = r_hdr_pos + 4'd1;
                    if (r_hdr_pos == 4'(svpp_pkg::COOKIE_LEN - 1)) begin
                        if (cookie_now == svpp_pkg::CK_NONE) begin
                            n_rejected = 1'b1;
                        end else begin
                            if (r_skip_left != '0) begin
                                n_skip_left = r_skip_left - 16'd1;
                                n_muted     = 1'b1;
                            end
                            if (cookie_now[0]) begin
                                n_cookie = svpp_pkg::CK_MASK;
                                n_lines  = '0;
                            end else begin
                                n_cookie  = svpp_pkg::CK_ALL;
                                n_lines   = '1;
                                n_hdr_pos = 4'(svpp_pkg::BODY_POS);
                            end
                        end
                    end
                end else if (r_hdr_pos < 4'(svpp_pkg::BODY_POS)) begin
                    // Little-endian mask bytes; only the low 36 bits count.
                    case (r_hdr_pos)
                        4'd4:    n_lines[7:0]   = r_lines[7:0]   | i_data.data_byte;
                        4'd5:    n_lines[15:8]  = r_lines[15:8]  | i_data.data_byte;
                        4'd6:    n_lines[23:16] = r_lines[23:16] | i_data.data_byte;
                        4'd7:    n_lines[31:24] = r_lines[31:24] | i_data.data_byte;
                        4'd8:    n_lines[35:32] = r_lines[35:32] | i_data.data_byte[3:0];
                        default: n_lines = r_lines;
                    endcase
                    n_hdr_pos = r_hdr_pos + 4'd1;
                end else begin
                    if (r_rec_pos == 6'd0) begin
                        n_rec_type = i_data.data_byte;
                    end
                    if (r_rec_pos == 6'(svpp_pkg::DATA_LEN)) begin
                        n_rec_pos = 6'd0;
                        n_lines   = r_lines & ~low_bit;
                    end else begin
                        n_rec_pos = r_rec_pos + 6'd1;
                    end
                end
            end

            if (i_data.last_byte) begin
                n_hdr_pos  = 4'd0;
                n_cookie   = svpp_pkg::CK_NONE;
                n_lines    = '0;
                n_rec_pos  = 6'd0;
                n_rejected = 1'b0;
                n_muted    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos   <= '0;
            r_cookie    <= svpp_pkg::CK_NONE;
            r_lines     <= '0;
            r_rec_pos   <= '0;
            r_rec_type  <= '0;
            r_rejected  <= 1'b0;
            r_muted     <= 1'b0;
            r_skip_left <= '0;
        end else begin
            r_hdr_pos   <= n_hdr_pos;
            r_cookie    <= n_cookie;
            r_lines     <= n_lines;
            r_rec_pos   <= n_rec_pos;
            r_rec_type  <= n_rec_type;
            r_rejected  <= n_rejected;
            r_muted     <= n_muted;
            r_skip_left <= n_skip_left;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/svpp_back.sv =====
// ----------------------------------------------------------------------------
// svpp_back: record buffer and output drain
// Holds the two record slots and emits the 42 data bytes of the record at
// the queue head through a registered output, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module svpp_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire svpp_pkg::t_buf_wr   i_buf_wr,
    input  wire svpp_pkg::t_q_status i_q_status,
    input  wire svpp_pkg::t_desc     i_head_desc,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output svpp_pkg::t_out           o_data
);

    logic [7:0] r_mem [svpp_pkg::MEM_DEPTH];

    logic [5:0] r_pos, n_pos;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_rdata;
    logic [8:0] r_line;
    logic [2:0] r_svc;
    logic [5:0] r_index;
    logic       r_last;

    logic advance;
    logic issue;
    logic at_end;

    // The output register moves whenever it is empty or being taken.
    assign advance = !r_out_valid || !i_stall;
    assign issue   = advance && !i_q_status.empty;
    assign at_end  = (r_pos == 6'(svpp_pkg::DATA_LEN - 1));
    assign o_pop   = issue && at_end;

    always_comb begin
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = !i_q_status.empty;
        end
        if (issue) begin
            n_pos = at_end ? 6'd0 : r_pos + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_buf_wr.en) begin
            r_mem[i_buf_wr.addr] <= i_buf_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rdata <= r_mem[{i_q_status.rd_slot, r_pos}];
            r_line  <= i_head_desc.line_number;
            r_svc   <= i_head_desc.service;
            r_index <= r_pos;
            r_last  <= at_end;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_data.line_number    = r_line;
    assign o_data.service        = r_svc;
    assign o_data.byte_index     = r_index;
    assign o_data.data_value     = r_rdata;
    assign o_data.last_of_record = r_last;

endmodule

`default_nettype wire

// ===== hw/rtl/sliced_vbi_packet_parser.sv =====
// ----------------------------------------------------------------------------
// sliced_vbi_packet_parser: sliced VBI packet parser
// Parses a byte stream of sliced VBI packets and emits the data bytes of each
// completed record tagged with its scan line and service code.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                      Direction  Moves
//   input     i_valid, o_stall, i_data     in         one packet byte
//   output    o_valid, i_stall, o_data     out        one record data byte
//   config    i_cfg_we, i_cfg_wdata        in         skip_packets value
//
// The parser takes one packet byte per cycle while o_stall is low, and the
// output side gives one record byte per cycle unless the output stalls. The
// first byte of a record is read only after its last byte is accepted and
// queued, and reaches the output through the output register; the other 41
// follow unless the output stalls. The front end stalls only while both
// record buffer slots hold records that the back end has not yet finished
// draining. An output stall holds the output register and the drain position;
// the front end keeps going until the slots fill. Reset is synchronous and
// active low; it returns the parser to the start of a packet with an empty
// record queue and a skip count of zero. No clearing pass follows reset.
//
`default_nettype none

module sliced_vbi_packet_parser (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire svpp_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_stall,
    output svpp_pkg::t_out      o_data,
    input  wire logic           i_cfg_we,
    input  wire logic [15:0]    i_cfg_wdata
);

    // Front end to queue and record buffer.
    logic                 push;
    svpp_pkg::t_desc      push_desc;
    svpp_pkg::t_buf_wr    buf_wr;

    // Queue to both ends.
    svpp_pkg::t_desc      head_desc;
    svpp_pkg::t_q_status  q_status;
    logic                 pop;

    // The front end decodes the header, tracks the line mask and the skip
    // count, and writes data bytes into the slot named by the queue's write
    // pointer. Records that are dropped or muted are simply not pushed, so
    // their slot is reused by the next record.
    svpp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_desc (push_desc),
        .o_buf_wr    (buf_wr)
    );

    // Each queue entry owns one record buffer slot until the back end has
    // issued the read of its last byte.
    svpp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_desc (push_desc),
        .i_pop       (pop),
        .o_head_desc (head_desc),
        .o_status    (q_status)
    );

    // The back end drains the head record one byte per transfer.
    svpp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_buf_wr    (buf_wr),
        .i_q_status  (q_status),
        .i_head_desc (head_desc),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

endmodule

`default_nettype wire
